// ===== rtl/pairwise_key_expansion_defines.svh =====
// Assertion macros shared by the pairwise key expansion RTL.
// Included by the modules that carry concurrent assertions.
`ifndef PAIRWISE_KEY_EXPANSION_DEFINES_SVH
`define PAIRWISE_KEY_EXPANSION_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define PKE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define PKE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pke_pkg.sv =====
// Package for the pairwise key expansion block: sizes, SHA-1 constants, types.
// Used by every module in rtl.
`timescale 1ns / 1ps
package pke_pkg;
    localparam int OUT_WORDS_DEF = 8;
    localparam int MSG_BITS      = 800;          // 100 message octets
    localparam int IN_BITS       = 608;          // tdata of one request
    localparam int QDEPTH        = 2;
    localparam logic [175:0] LABEL = "Pairwise key expansion";
    localparam logic [159:0] SHA_IV =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

    // Ordered message body: addresses and nonces, 76 octets, first octet high.
    typedef logic [607:0] t_body;

    typedef enum logic [2:0] {
        S_IDLE, S_INNER0, S_INNER1, S_INNER2, S_OUTER0, S_OUTER1, S_EMIT
    } t_state;

    typedef struct packed {
        logic       start;   // compress a block now
        logic [511:0] blk;
        logic [159:0] hin;
    } t_sha_req;

    typedef struct packed {
        logic         done;
        logic [159:0] hout;
    } t_sha_rsp;

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        rol = (x << n) | (x >> (32 - n));
    endfunction
endpackage

// ===== rtl/pke_front.sv =====
// Front end: accepts requests, orders addresses and nonces, writes a queue.
// Depends on pke_pkg.
`timescale 1ns / 1ps
module pke_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [607:0]    i_data,
    output logic            o_q_valid,
    input  logic            i_q_pop,
    output pke_pkg::t_body  o_q_body
);
    import pke_pkg::*;

    logic [47:0]  w_aa, w_sa, w_lo_a, w_hi_a;
    logic [255:0] w_an, w_sn, w_lo_n, w_hi_n;
    t_body        r_q [QDEPTH];
    logic         r_wp, r_rp, n_wp, n_rp;
    logic [1:0]   r_cnt, n_cnt;
    logic         w_push;

    assign w_aa = i_data[47:0];
    assign w_sa = i_data[95:48];
    assign w_an = {i_data[159:96], i_data[223:160], i_data[287:224], i_data[351:288]};
    assign w_sn = {i_data[415:352], i_data[479:416], i_data[543:480], i_data[607:544]};

    // Byte-wise order with first byte high equals a plain unsigned compare.
    always_comb begin
        w_lo_a = (w_aa < w_sa) ? w_aa : w_sa;
        w_hi_a = (w_aa < w_sa) ? w_sa : w_aa;
        w_lo_n = (w_an < w_sn) ? w_an : w_sn;
        w_hi_n = (w_an < w_sn) ? w_sn : w_an;
    end

    assign o_ready   = (r_cnt != 2'(QDEPTH));
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_body  = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp ^ w_push;
        n_rp  = r_rp ^ (i_q_pop && o_q_valid);
        n_cnt = r_cnt + 2'(w_push) - 2'(i_q_pop && o_q_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_q[r_wp] <= {w_lo_a, w_hi_a, w_lo_n, w_hi_n};
        end
    end
endmodule

// ===== rtl/pke_sha1.sv =====
// Iterative SHA-1 compression, one round per cycle, 16-word schedule window.
// Depends on pke_pkg.
`timescale 1ns / 1ps
module pke_sha1 (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pke_pkg::t_sha_req i_req,
    output pke_pkg::t_sha_rsp o_rsp
);
    import pke_pkg::*;

    logic [31:0]  r_w [16];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [159:0] r_h;
    logic [6:0]   r_rnd;
    logic         r_busy, r_done;
    logic [31:0]  w_f, w_k, w_t, w_new;

    always_comb begin
        if (r_rnd < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d); w_k = 32'h5A827999;
        end else if (r_rnd < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d; w_k = 32'h6ED9EBA1;
        end else if (r_rnd < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d); w_k = 32'h8F1BBCDC;
        end else begin
            w_f = r_b ^ r_c ^ r_d; w_k = 32'hCA62C1D6;
        end
        w_t   = rol(r_a, 5) + w_f + r_e + w_k + r_w[0];
        w_new = rol(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0], 1);
    end

    assign o_rsp.done = r_done;
    assign o_rsp.hout = {r_h[159:128] + r_a, r_h[127:96] + r_b, r_h[95:64] + r_c,
                         r_h[63:32] + r_d, r_h[31:0] + r_e};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= 7'd0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_rnd == 7'd79);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_rnd  <= 7'd0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 7'd1;
                if (r_rnd == 7'd79) begin
                    r_busy <= 1'b0;
                end
            end
        end
        if (i_req.start) begin
            for (int i = 0; i < 16; i++) r_w[i] <= i_req.blk[511 - 32*i -: 32];
            r_h <= i_req.hin;
            {r_a, r_b, r_c, r_d, r_e} <= i_req.hin;
        end else if (r_busy) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
            r_e <= r_d; r_d <= r_c; r_c <= rol(r_b, 30); r_b <= r_a; r_a <= w_t;
        end
    end

    `include "pairwise_key_expansion_defines.svh"
    `PKE_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done, "done lasts one cycle")
    `PKE_ASSERT_IMP(a_busy_rnd, i_clk, i_rst_n, r_busy, r_rnd < 7'd80, "round out of range")
    `PKE_ASSERT_NXT(a_start_idle, i_clk, i_rst_n, i_req.start, r_busy, "start ignored")
endmodule

// ===== rtl/pke_back.sv =====
// Back end: HMAC-SHA1 sequencer over the shared compression unit, output shift register.
// Depends on pke_pkg and pke_sha1.
`timescale 1ns / 1ps
module pke_back #(
    parameter int OUT_WORDS = pke_pkg::OUT_WORDS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [255:0]   i_key,
    input  logic           i_q_valid,
    output logic           o_q_pop,
    input  pke_pkg::t_body i_q_body,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [63:0]    o_word,
    output logic [3:0]     o_index,
    output logic           o_last
);
    import pke_pkg::*;

    localparam int NDIG  = (OUT_WORDS * 8 + 19) / 20;
    localparam int SBITS = NDIG * 160;

    t_state          r_st, n_st;
    t_body           r_body;
    logic [2:0]      r_ctr;
    logic [159:0]    r_hi;          // state after the inner pad block
    logic [159:0]    r_ho;          // state after the outer pad block
    logic [159:0]    r_hx;
    logic [SBITS-1:0] r_str;
    logic [3:0]      r_wi;
    t_sha_req        w_req;
    t_sha_rsp        w_rsp;
    logic [511:0]    w_ipad, w_opad, w_b1, w_b2, w_ob;
    logic [799:0]    w_msg;

    always_comb begin
        w_ipad = {i_key ^ {32{8'h36}}, {32{8'h36}}};
        w_opad = {i_key ^ {32{8'h5C}}, {32{8'h5C}}};
        w_msg  = {LABEL, 8'h00, r_body, 5'd0, r_ctr};
        w_b1   = w_msg[799:288];
        // 36 remaining octets, 0x80, zeros, 164*8 bit length
        w_b2   = {w_msg[287:0], 8'h80, 152'd0, 64'd1312};
        w_ob   = {r_hx, 8'h80, 280'd0, 64'd672};
    end

    pke_sha1 u_sha (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    assign o_valid = (r_st == S_EMIT);
    assign o_word  = r_str[SBITS-1 -: 64];
    assign o_index = r_wi;
    assign o_last  = (r_wi == 4'(OUT_WORDS - 1));
    assign o_q_pop = (r_st == S_IDLE) && i_q_valid;

    // Steps: key pads (once per request), then per counter two inner and one
    // outer compression. S_INNER0 runs both pad blocks, the inner one first and
    // then the outer one, computed each request so key writes while idle are
    // honoured.
    logic r_pad;   // 0 = inner-pad prefix pass, 1 = outer-pad prefix pass
    logic r_go;
    always_comb begin
        n_st        = r_st;
        w_req.start = 1'b0;
        w_req.blk   = w_b1;
        w_req.hin   = r_hi;
        case (r_st)
            S_IDLE: if (i_q_valid) n_st = S_INNER0;
            S_INNER0: begin
                w_req.blk = r_pad ? w_opad : w_ipad;
                w_req.hin = SHA_IV;
                w_req.start = r_go;
                if (w_rsp.done) n_st = r_pad ? S_INNER1 : S_INNER0;
            end
            S_INNER1: begin
                w_req.start = r_go;
                w_req.blk = w_b1; w_req.hin = r_hi;
                if (w_rsp.done) n_st = S_INNER2;
            end
            S_INNER2: begin
                w_req.start = r_go;
                w_req.blk = w_b2; w_req.hin = r_hx;
                if (w_rsp.done) n_st = S_OUTER1;
            end
            S_OUTER1: begin
                w_req.start = r_go;
                w_req.blk = w_ob; w_req.hin = r_ho;
                if (w_rsp.done) n_st = (r_ctr == 3'(NDIG - 1)) ? S_EMIT : S_INNER1;
            end
            S_OUTER0: n_st = S_IDLE;
            S_EMIT: if (i_ready && o_last) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_go  <= 1'b0;
            r_pad <= 1'b0;
            r_ctr <= 3'd0;
            r_wi  <= 4'd0;
        end else begin
            r_st <= n_st;
            r_go <= (r_st == S_IDLE && i_q_valid) || w_rsp.done;
            if (r_st == S_IDLE && i_q_valid) begin
                r_pad <= 1'b0; r_ctr <= 3'd0; r_wi <= 4'd0;
            end
            if (r_st == S_INNER0 && w_rsp.done) r_pad <= 1'b1;
            if (r_st == S_OUTER1 && w_rsp.done) r_ctr <= r_ctr + 3'd1;
            if (o_valid && i_ready) r_wi <= o_last ? 4'd0 : r_wi + 4'd1;
        end
        if (o_q_pop) r_body <= i_q_body;
        if (w_rsp.done) begin
            case (r_st)
                S_INNER0: if (r_pad) r_ho <= w_rsp.hout; else r_hi <= w_rsp.hout;
                S_INNER1: r_hx <= w_rsp.hout;
                S_INNER2: r_hx <= w_rsp.hout;
                S_OUTER1: r_str[SBITS-1 - 160*r_ctr -: 160] <= w_rsp.hout;
                default: ;
            endcase
        end
        if (o_valid && i_ready) r_str <= r_str << 64;
    end

    `include "pairwise_key_expansion_defines.svh"
    `PKE_ASSERT_IMP(a_idx_rng, i_clk, i_rst_n, o_valid, r_wi < 4'(OUT_WORDS), "index range")
    `PKE_ASSERT_IMP(a_pop_idle, i_clk, i_rst_n, o_q_pop, r_st == S_IDLE, "pop while busy")
    `PKE_ASSERT_NXT(a_last_idle, i_clk, i_rst_n, o_valid && i_ready && o_last,
        r_st == S_IDLE, "no idle after last")
endmodule

// ===== rtl/pairwise_key_expansion.sv =====
// Top level of the pairwise key expansion block (PRF-512 over HMAC-SHA1).
// Instantiates pke_front and pke_back; uses pke_pkg.
//
// Usage: write the 256-bit master key through i_cfg_we/i_cfg_idx/i_cfg_data
// (indices 0 to 3, first key byte most significant) while the block is idle.
// Each request on the s_axis channel carries both addresses and both nonces;
// the block answers with OUT_WORDS words on m_axis, the last marked by tlast.
// The front orders addresses and nonces and queues up to two requests, so a
// new request is accepted while the back end is still busy or stalled.
// The back end runs one shared SHA-1 round unit, one round per cycle: two
// pad-block compressions per request plus three compressions per digest,
// with ceil(OUT_WORDS * 8 / 20) digests per request, then the OUT_WORDS
// output words.
// Reset (synchronous, active low) empties the queue, idles the back end and
// clears the key to zero. When the receiver stalls, the current word holds
// on m_axis and the back end waits; the front keeps accepting until full.
`timescale 1ns / 1ps
module pairwise_key_expansion #(
    parameter int OUT_WORDS = pke_pkg::OUT_WORDS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // auth_addr, supp_addr, auth_nonce_0..3, supp_nonce_0..3 (lowest first)
    input  logic [607:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // key_word, word_index, then 4 zero bits (lowest first)
    output logic [71:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [63:0]  i_cfg_data
);
    import pke_pkg::*;

    logic [63:0] r_key [4];
    logic        w_qv, w_pop;
    t_body       w_body;
    logic [63:0] w_word;
    logic [3:0]  w_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_key[i] <= 64'd0;
        end else if (i_cfg_we) begin
            r_key[i_cfg_idx] <= i_cfg_data;
        end
    end

    pke_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_data(s_axis_tdata),
        .o_q_valid(w_qv), .i_q_pop(w_pop), .o_q_body(w_body)
    );

    pke_back #(.OUT_WORDS(OUT_WORDS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_key({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .i_q_valid(w_qv), .o_q_pop(w_pop), .i_q_body(w_body),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_word(w_word), .o_index(w_idx), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, w_idx, w_word};
endmodule
